[rtl/core/integer_square_root_assert.svh]
// ---------------------------------------------------------------------------
// integer_square_root assertion macros
// shared property forms for the square root pipeline checks
// ---------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ISR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_square_root: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ISR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_square_root: next-cycle check failed");

`endif

[rtl/core/isr_pkg.sv]
// ---------------------------------------------------------------------------
// isr_pkg
// widths and defaults shared by the square root pipeline
// ---------------------------------------------------------------------------
package isr_pkg;

  localparam int RADICAND_W         = 64;
  localparam int ROOT_OUT_W         = 32;
  localparam int ROOT_WIDTH_DEFAULT = 32;

endpackage

[rtl/core/integer_square_root.sv]
// an accepted start passes through every registered cell before its out_valid strobe
// throughput: one transaction per cycle; busy stays low, one cell per root bit
// each result is shown for exactly one cycle; the receiver cannot stall
// reset: synchronous active-low rst_n clears every cell valid bit, dropping
// any transaction in flight; payload registers are not reset
// ---------------------------------------------------------------------------
// integer_square_root
// pipelined non-restoring floor square root of a 64-bit unsigned radicand
// ---------------------------------------------------------------------------
`include "integer_square_root_assert.svh"

module integer_square_root #(
  parameter int ROOT_WIDTH = isr_pkg::ROOT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [isr_pkg::RADICAND_W-1:0] in_radicand,
  output logic                          out_valid,
  output logic [isr_pkg::ROOT_OUT_W-1:0] out_root
);

  localparam int REM_W = ROOT_WIDTH + 3;
  localparam int OW    = isr_pkg::ROOT_OUT_W;

  logic                    vld_c  [ROOT_WIDTH+1];
  logic [2*ROOT_WIDTH-1:0] rad_c  [ROOT_WIDTH+1];
  logic [REM_W-1:0]        rem_c  [ROOT_WIDTH+1];
  logic [ROOT_WIDTH-1:0]   root_c [ROOT_WIDTH+1];

  assign busy      = 1'b0;
  assign vld_c[0]  = start & ~busy;
  assign rad_c[0]  = in_radicand[2*ROOT_WIDTH-1:0];
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_cell
    isr_cell #(
      .ROOT_WIDTH (ROOT_WIDTH),
      .STEP       (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_c[i]),
      .rad_i  (rad_c[i]),
      .rem_i  (rem_c[i]),
      .root_i (root_c[i]),
      .vld_o  (vld_c[i+1]),
      .rad_o  (rad_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .root_o (root_c[i+1])
    );
  end

  assign out_valid = vld_c[ROOT_WIDTH];
  assign out_root  = OW'(root_c[ROOT_WIDTH]);

  // a result only follows an accepted transaction that has passed through every cell
  `ISR_ASSERT_IMPL(a_out_follows_start, clk, rst_n, out_valid, $past(start && !busy, ROOT_WIDTH))
  // last root bit agrees with the sign of the final remainder
  `ISR_ASSERT_IMPL(a_lsb_sign, clk, rst_n, out_valid, root_c[ROOT_WIDTH][0] == !rem_c[ROOT_WIDTH][REM_W-1])
  // an accepted transaction enters the first cell
  `ISR_ASSERT_NEXT(a_first_cell, clk, rst_n, start && !busy, vld_c[1])

endmodule

[rtl/core/isr_cell.sv]
// ---------------------------------------------------------------------------
// isr_cell
// one non-restoring recurrence step, registered, producing one root bit
// ---------------------------------------------------------------------------
module isr_cell #(
  parameter int ROOT_WIDTH = isr_pkg::ROOT_WIDTH_DEFAULT,
  parameter int STEP       = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  logic [2*ROOT_WIDTH-1:0] rad_i,
  input  logic [ROOT_WIDTH+2:0]   rem_i,
  input  logic [ROOT_WIDTH-1:0]   root_i,
  output logic                    vld_o,
  output logic [2*ROOT_WIDTH-1:0] rad_o,
  output logic [ROOT_WIDTH+2:0]   rem_o,
  output logic [ROOT_WIDTH-1:0]   root_o
);

  localparam int REM_W  = ROOT_WIDTH + 3;
  localparam int PAIR_L = 2 * (ROOT_WIDTH - 1 - STEP);

  logic                    vld_r;
  logic [2*ROOT_WIDTH-1:0] rad_r;
  logic [REM_W-1:0]        rem_r;
  logic [ROOT_WIDTH-1:0]   root_r;

  logic [1:0]              pair;
  logic [REM_W-1:0]        shifted;
  logic [REM_W-1:0]        opd;
  logic [REM_W-1:0]        rem_nxt;
  logic [ROOT_WIDTH:0]     root_cat;
  logic [ROOT_WIDTH-1:0]   root_nxt;

  assign pair    = rad_i[PAIR_L +: 2];
  assign shifted = {rem_i[REM_W-3:0], pair};
  assign opd     = rem_i[REM_W-1] ? {1'b0, root_i, 2'b11} : {1'b0, root_i, 2'b01};

  // negative remainder adds, otherwise subtracts
  assign rem_nxt  = rem_i[REM_W-1] ? (shifted + opd) : (shifted - opd);
  assign root_cat = {root_i, ~rem_nxt[REM_W-1]};
  assign root_nxt = root_cat[ROOT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_i;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
